>>> hdl/dwcs_pkg.sv
// Types, constants and fixed-point helpers for the damped wave chain core.
// Used by every module of the block; no dependencies.
package dwcs_pkg;

  typedef struct packed {
    logic signed [23:0] height;
    logic signed [23:0] velocity;
    logic        [16:0] energy;
  } point_t;

  typedef struct packed {
    logic shift;
    logic clr;
  } cell_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STEP_A,
    ST_STEP_B,
    ST_STEP_C,
    ST_STEP_D,
    ST_PASS,
    ST_TURB_R1,
    ST_TURB_R2,
    ST_TURB_M1,
    ST_TURB_M2,
    ST_TURB_PASS,
    ST_EMIT
  } state_t;

  localparam logic [2:0] REQ_STEP    = 3'd0;
  localparam logic [2:0] REQ_IMPULSE = 3'd1;
  localparam logic [2:0] REQ_EXCITE  = 3'd2;
  localparam logic [2:0] REQ_TURB    = 3'd3;
  localparam logic [2:0] REQ_CLEAR   = 3'd4;
  localparam logic [2:0] REQ_READ    = 3'd5;

  localparam logic signed [31:0] Q_COUPLING  = 32'sd4915;
  localparam logic signed [31:0] Q_STIFFNESS = 32'sd328;
  localparam logic signed [31:0] Q_DAMPING   = 32'sd15401;
  localparam logic signed [31:0] Q_DECAY     = 32'sd15073;
  localparam logic signed [31:0] Q_EXCITE    = 32'sd1966;
  localparam logic signed [31:0] Q_TURB      = 32'sd5734;
  localparam logic signed [31:0] Q_BREATH    = 32'sd983;
  localparam logic signed [31:0] Q_H0        = 32'sd4915;
  localparam logic signed [31:0] Q_H1        = 32'sd2621;
  localparam logic signed [31:0] Q_H2        = 32'sd1311;

  localparam logic signed [63:0] Y_BOUND = 64'sd458752;
  localparam logic signed [63:0] E_MAX   = 64'sd65536;
  localparam logic signed [63:0] S24_MAX = 64'sd8388607;
  localparam logic signed [63:0] S24_MIN = -64'sd8388608;

  localparam logic [31:0] SEED_RESET = 32'd2463534242;

  localparam logic [15:0] PHASE0_RESET = 16'd0;
  localparam logic [15:0] PHASE1_RESET = 16'd17000;
  localparam logic [15:0] PHASE2_RESET = 16'd41000;
  localparam logic [15:0] PHASE0_INC   = 16'd210;
  localparam logic [15:0] PHASE1_INC   = 16'd347;
  localparam logic [15:0] PHASE2_INC   = 16'd89;

  function automatic logic signed [63:0] mulq(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return (p + 64'sd8192) >>> 14;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    if (v > S24_MAX) return 24'sh7FFFFF;
    if (v < S24_MIN) return 24'sh800000;
    return 24'(v);
  endfunction

  function automatic logic signed [23:0] clamp_height(input logic signed [63:0] v);
    if (v > Y_BOUND) return 24'(Y_BOUND);
    if (v < -Y_BOUND) return 24'(-Y_BOUND);
    return 24'(v);
  endfunction

  function automatic logic [16:0] clamp_energy(input logic signed [63:0] v);
    if (v > E_MAX) return 17'(E_MAX);
    if (v < 64'sd0) return 17'd0;
    return 17'(v);
  endfunction

  function automatic logic signed [15:0] quarter_sine(input logic [4:0] r);
    case (r)
      5'd0:  return 16'sd0;
      5'd1:  return 16'sd1606;
      5'd2:  return 16'sd3196;
      5'd3:  return 16'sd4756;
      5'd4:  return 16'sd6270;
      5'd5:  return 16'sd7723;
      5'd6:  return 16'sd9102;
      5'd7:  return 16'sd10394;
      5'd8:  return 16'sd11585;
      5'd9:  return 16'sd12665;
      5'd10: return 16'sd13623;
      5'd11: return 16'sd14449;
      5'd12: return 16'sd15137;
      5'd13: return 16'sd15679;
      5'd14: return 16'sd16069;
      5'd15: return 16'sd16305;
      5'd16: return 16'sd16384;
      default: return 16'sd0;
    endcase
  endfunction

  function automatic logic signed [15:0] table_sin(input logic [15:0] phase);
    logic [4:0] r;
    logic [4:0] rm;
    r  = {1'b0, phase[13:10]};
    rm = 5'd16 - r;
    case (phase[15:14])
      2'd0: return quarter_sine(r);
      2'd1: return quarter_sine(rm);
      2'd2: return -quarter_sine(r);
      default: return -quarter_sine(rm);
    endcase
  endfunction

endpackage

>>> hdl/dwcs_cell.sv
// One point of the wave chain: height, velocity and energy.
// Loads its neighbor's point on shift; clears on clr. Uses dwcs_pkg.
module dwcs_cell (
  input  logic              clk,
  input  logic              rst,
  input  dwcs_pkg::cell_ctl_t ctl,
  input  dwcs_pkg::point_t  din,
  output dwcs_pkg::point_t  q
);
  import dwcs_pkg::*;

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      q <= '0;
    end else if (ctl.shift) begin
      q <= din;
    end
  end

endmodule

>>> hdl/dwcs_rng.sv
// Xorshift32 noise generator with seed load.
// Uses dwcs_pkg for the reset seed.
module dwcs_rng (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  logic        adv,
  input  logic [31:0] seed,
  output logic [31:0] rnd
);
  import dwcs_pkg::*;

  logic [31:0] state;
  logic [31:0] s1;
  logic [31:0] s2;

  always_comb begin
    s1  = state ^ (state << 13);
    s2  = s1 ^ (s1 >> 17);
    rnd = s2 ^ (s2 << 5);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEED_RESET;
    end else if (load) begin
      state <= seed;
    end else if (adv) begin
      state <= rnd;
    end
  end

endmodule

>>> hdl/damped_wave_chain_sim_core.sv
// Damped wave chain core: a ring of point cells rotating past one shared update unit.
// Uses dwcs_pkg, dwcs_cell and dwcs_rng.
//
// The points sit in a ring of WAVE_POINTS cells that rotates by one place past a single
// update unit at its head, so step, impulse, excite and read each cost one full turn of
// the ring. One request is handled at a time. Step passes each point through states
// STEP_A to STEP_D, the multiplier stages of the update unit; impulse, excite and read
// pass each point once; turbulence makes eight kicks of one turn each. Clear, unknown
// requests and turbulence without a positive amount do not turn the ring. The result
// then waits in an output register, and the next request can be taken in the cycle
// after the result is loaded there.
// WAVE_POINTS must be a power of two. The seed port is always ready and should be written
// only while the block is idle.
module damped_wave_chain_sim_core #(
  parameter int WAVE_POINTS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         req_type,
  input  logic [5:0]         position,
  input  logic signed [23:0] amount,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] point_height,
  output logic signed [23:0] point_velocity,
  output logic [16:0]        point_energy,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        noise_seed
);
  import dwcs_pkg::*;

  localparam int PW = $clog2(WAVE_POINTS);
  localparam logic [PW-1:0] LAST = PW'(WAVE_POINTS - 1);

  state_t state, state_next;

  point_t    cell_q   [WAVE_POINTS];
  point_t    cell_din [WAVE_POINTS];
  point_t    head_new;
  cell_ctl_t ctl;

  logic [31:0] seed;
  logic [31:0] rnd;
  logic        rng_load;
  logic        rng_adv;

  logic [PW-1:0]      ptr;
  logic [2:0]         op;
  logic [5:0]         pos_r;
  logic signed [23:0] amt;
  logic               breath;
  logic signed [23:0] gain;
  logic [PW-1:0]      kidx;
  logic signed [14:0] unit;
  logic signed [24:0] t1;
  logic signed [24:0] kick;
  logic [2:0]         kcnt;
  logic [15:0]        ph0, ph1, ph2;
  logic signed [23:0] prev_y;
  logic signed [23:0] p_lap, p_stf;
  logic signed [15:0] hs0, hs1, hs2;
  logic signed [23:0] vd;
  logic signed [24:0] hq;
  logic [16:0]        en;
  logic signed [23:0] pull;
  logic signed [23:0] res_h, res_v;
  logic [16:0]        res_e;

  logic               accept;
  logic               last;
  logic signed [23:0] y, left, right;
  logic [15:0]        x1, x3, x7;
  logic signed [15:0] dd, dabs;
  logic signed [3:0]  w;
  logic               near;
  logic signed [31:0] mag;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign last      = (ptr == LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_RESET;
    end else if (cfg_valid && cfg_ready) begin
      seed <= noise_seed;
    end
  end

  dwcs_rng u_rng (
    .clk  (clk),
    .rst  (rst),
    .load (rng_load),
    .adv  (rng_adv),
    .seed (seed),
    .rnd  (rnd)
  );

  for (genvar k = 0; k < WAVE_POINTS; k++) begin : g_cell
    if (k == WAVE_POINTS - 1) begin : g_tail
      assign cell_din[k] = head_new;
    end else begin : g_body
      assign cell_din[k] = cell_q[k+1];
    end
    dwcs_cell u_cell (
      .clk (clk),
      .rst (rst),
      .ctl (ctl),
      .din (cell_din[k]),
      .q   (cell_q[k])
    );
  end

  always_comb begin
    y     = cell_q[0].height;
    left  = (ptr == '0) ? y : prev_y;
    right = last ? y : cell_q[1].height;
    x1    = 16'(32'(ptr) << 9);
    x3    = x1 + (x1 << 1);
    x7    = (x1 << 3) - x1;
    dd    = $signed(16'(ptr)) - $signed(16'(pos_r));
    dabs  = (dd < 16'sd0) ? -dd : dd;
    near  = (dd >= -16'sd3) && (dd <= 16'sd3);
    w     = 4'sd4 - 4'(dabs);
    mag   = (amt < 24'sd0) ? -32'(amt) : 32'(amt);
  end

  always_comb begin
    head_new = cell_q[0];
    case (state)
      ST_STEP_D: begin
        head_new.height   = clamp_height(64'(y) + 64'(vd));
        head_new.velocity = breath ? sat24(64'(vd) + 64'(pull)) : vd;
        head_new.energy   = en;
      end
      ST_PASS: begin
        case (op)
          REQ_IMPULSE: begin
            if (near) begin
              head_new.velocity = sat24(64'(cell_q[0].velocity)
                + 64'((32'(amt) * 32'(w) + 32'sd2) >>> 2));
              head_new.energy = clamp_energy(64'($signed({1'b0, cell_q[0].energy}))
                + 64'((mag * 32'(w) + 32'sd2) >>> 2));
            end
          end
          REQ_EXCITE: begin
            head_new.energy = clamp_energy(64'($signed({1'b0, cell_q[0].energy}))
              + 64'(gain));
          end
          default: begin
          end
        endcase
      end
      ST_TURB_PASS: begin
        if (ptr == kidx) begin
          head_new.velocity = sat24(64'(cell_q[0].velocity) + 64'(kick));
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    ctl.shift  = 1'b0;
    ctl.clr    = 1'b0;
    rng_load   = 1'b0;
    rng_adv    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (req_type)
            REQ_STEP:    state_next = ST_STEP_A;
            REQ_IMPULSE: state_next = ST_PASS;
            REQ_EXCITE:  state_next = ST_PASS;
            REQ_READ:    state_next = ST_PASS;
            REQ_TURB:    state_next = (amount > 24'sd0) ? ST_TURB_R1 : ST_EMIT;
            REQ_CLEAR: begin
              ctl.clr    = 1'b1;
              rng_load   = 1'b1;
              state_next = ST_EMIT;
            end
            default:     state_next = ST_EMIT;
          endcase
        end
      end
      ST_STEP_A: state_next = ST_STEP_B;
      ST_STEP_B: state_next = ST_STEP_C;
      ST_STEP_C: state_next = ST_STEP_D;
      ST_STEP_D: begin
        ctl.shift  = 1'b1;
        state_next = last ? ST_EMIT : ST_STEP_A;
      end
      ST_PASS: begin
        ctl.shift = 1'b1;
        if (last) state_next = ST_EMIT;
      end
      ST_TURB_R1: begin
        rng_adv    = 1'b1;
        state_next = ST_TURB_R2;
      end
      ST_TURB_R2: begin
        rng_adv    = 1'b1;
        state_next = ST_TURB_M1;
      end
      ST_TURB_M1: state_next = ST_TURB_M2;
      ST_TURB_M2: state_next = ST_TURB_PASS;
      ST_TURB_PASS: begin
        ctl.shift = 1'b1;
        if (last) state_next = (kcnt == 3'd7) ? ST_EMIT : ST_TURB_R1;
      end
      ST_EMIT: begin
        if (!out_valid || !out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr  <= '0;
      kcnt <= '0;
      ph0  <= PHASE0_RESET;
      ph1  <= PHASE1_RESET;
      ph2  <= PHASE2_RESET;
    end else begin
      if (ctl.shift) ptr <= ptr + 1'b1;
      if (accept && req_type == REQ_CLEAR) begin
        ph0 <= PHASE0_RESET;
        ph1 <= PHASE1_RESET;
        ph2 <= PHASE2_RESET;
      end else if (accept && req_type == REQ_STEP) begin
        ph0 <= ph0 + PHASE0_INC;
        ph1 <= ph1 + PHASE1_INC;
        ph2 <= ph2 + PHASE2_INC;
      end
      if (accept) begin
        kcnt <= '0;
      end else if (state == ST_TURB_PASS && last) begin
        kcnt <= kcnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op     <= req_type;
      pos_r  <= position;
      amt    <= amount;
      breath <= (amount > 24'sd0);
      gain   <= 24'(mulq(32'(amount), Q_EXCITE));
      res_h  <= '0;
      res_v  <= '0;
      res_e  <= '0;
    end
    case (state)
      ST_STEP_A: begin
        p_lap <= 24'(mulq(32'(left) + 32'(right) - (32'(y) <<< 1), Q_COUPLING));
        p_stf <= 24'(mulq(32'(y), Q_STIFFNESS));
        hs0   <= 16'(mulq(32'(table_sin(ph0 + x1)), Q_H0));
        hs1   <= 16'(mulq(32'(table_sin(ph1 + x3)), Q_H1));
        hs2   <= 16'(mulq(32'(table_sin(ph2 + x7)), Q_H2));
      end
      ST_STEP_B: begin
        vd <= sat24(mulq(32'(cell_q[0].velocity) + 32'(p_lap) - 32'(p_stf), Q_DAMPING));
        hq <= 25'(mulq(32'(hs0) + 32'(hs1) + 32'(hs2), 32'(amt)));
        en <= 17'(mulq(32'($signed({1'b0, cell_q[0].energy})), Q_DECAY));
      end
      ST_STEP_C: begin
        if (!ptr[0]) pull <= 24'(mulq(32'(hq), Q_BREATH));
      end
      ST_STEP_D: begin
        prev_y <= y;
      end
      ST_PASS: begin
        if (op == REQ_READ && 32'(ptr) == 32'(pos_r) && 32'(pos_r) < WAVE_POINTS) begin
          res_h <= cell_q[0].height;
          res_v <= cell_q[0].velocity;
          res_e <= cell_q[0].energy;
        end
      end
      ST_TURB_R1: kidx <= rnd[PW-1:0];
      ST_TURB_R2: unit <= 15'($signed(rnd) >>> 17);
      ST_TURB_M1: t1 <= 25'(mulq(32'(unit), 32'(amt)));
      ST_TURB_M2: kick <= 25'(mulq(32'(t1), Q_TURB));
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && (!out_valid || !out_stall)) begin
      point_height   <= res_h;
      point_velocity <= res_v;
      point_energy   <= res_e;
    end
  end

  a_idle_aligned: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> ptr == '0)
    else $error("ring not aligned while idle");

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    accept && req_type == REQ_CLEAR |=> cell_q[0] == '0 && ph1 == PHASE1_RESET)
    else $error("clear did not empty the chain");

  a_energy_bound: assert property (@(posedge clk) disable iff (rst)
    64'($signed({1'b0, cell_q[0].energy})) <= E_MAX)
    else $error("energy above limit");

  a_height_bound: assert property (@(posedge clk) disable iff (rst)
    64'(cell_q[0].height) <= Y_BOUND && 64'(cell_q[0].height) >= -Y_BOUND)
    else $error("height outside clamp");

endmodule

>>> tb/dwcs_checker.sv
// Checker for the damped wave chain core: watches the request, result and seed channels.
// Predicts each result from its own model of the chain and counts mismatches.
// Depends on dwcs_pkg for request codes, reset constants and phase increments.
module dwcs_checker #(
  parameter int WAVE_POINTS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [2:0]         req_type,
  input  logic [5:0]         position,
  input  logic signed [23:0] amount,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [23:0] point_height,
  input  logic signed [23:0] point_velocity,
  input  logic [16:0]        point_energy,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [31:0]        noise_seed,
  output int                 errors,
  output int                 pending,
  output int                 reads_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import dwcs_pkg::*;

  typedef struct packed {
    logic signed [23:0] h;
    logic signed [23:0] v;
    logic [16:0]        e;
  } read_t;

  localparam longint SINE_Q [17] = '{0, 1606, 3196, 4756, 6270, 7723, 9102, 10394, 11585,
                                    12665, 13623, 14449, 15137, 15679, 16069, 16305, 16384};

  logic [31:0] seed_reg;
  longint      hgt [WAVE_POINTS];
  longint      vel [WAVE_POINTS];
  longint      nrg [WAVE_POINTS];
  logic [15:0] ph [3];
  logic [31:0] lfsr;
  read_t       read_q [$];

  function automatic longint fshr(longint x, int s);
    return x >>> s;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return fshr(a * b + 8192, 14);
  endfunction

  function automatic longint clampl(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic longint sine_of(logic [15:0] p);
    int idx;
    int r;
    idx = p[15:10];
    r = idx & 15;
    case (idx >> 4)
      0: return SINE_Q[r];
      1: return SINE_Q[16 - r];
      2: return -SINE_Q[r];
      default: return -SINE_Q[16 - r];
    endcase
  endfunction

  function automatic logic [31:0] rand_next();
    lfsr = lfsr ^ (lfsr << 13);
    lfsr = lfsr ^ (lfsr >> 17);
    lfsr = lfsr ^ (lfsr << 5);
    return lfsr;
  endfunction

  task automatic wipe_chain();
    for (int i = 0; i < WAVE_POINTS; i++) begin
      hgt[i] = 0;
      vel[i] = 0;
      nrg[i] = 0;
    end
    ph[0] = PHASE0_RESET;
    ph[1] = PHASE1_RESET;
    ph[2] = PHASE2_RESET;
    lfsr = seed_reg;
  endtask

  task automatic advance_chain(longint amt);
    longint prev [WAVE_POINTS];
    longint y, l, r, acc, h, pull;
    logic [15:0] x;
    ph[0] = ph[0] + PHASE0_INC;
    ph[1] = ph[1] + PHASE1_INC;
    ph[2] = ph[2] + PHASE2_INC;
    for (int i = 0; i < WAVE_POINTS; i++) prev[i] = hgt[i];
    for (int i = 0; i < WAVE_POINTS; i++) begin
      y = prev[i];
      l = prev[i == 0 ? 0 : i - 1];
      r = prev[i == WAVE_POINTS - 1 ? i : i + 1];
      acc = qmul(l + r - 2 * y, 4915) - qmul(y, 328);
      vel[i] = clampl(qmul(vel[i] + acc, 15401), -8388608, 8388607);
      hgt[i] = clampl(y + vel[i], -458752, 458752);
      nrg[i] = qmul(nrg[i], 15073);
    end
    if (amt <= 0) return;
    for (int i = 0; i < WAVE_POINTS; i += 2) begin
      x = 16'(i * 512);
      h = qmul(sine_of(ph[0] + x), 4915) + qmul(sine_of(ph[1] + 16'(3 * x)), 2621)
        + qmul(sine_of(ph[2] + 16'(7 * x)), 1311);
      pull = qmul(qmul(h, amt), 983);
      vel[i] = clampl(vel[i] + pull, -8388608, 8388607);
      if (i + 1 < WAVE_POINTS) vel[i + 1] = clampl(vel[i + 1] + pull, -8388608, 8388607);
    end
  endtask

  task automatic apply_request(logic [2:0] kind, int pos, longint amt);
    read_t res;
    longint mag, w, unit;
    int idx;
    logic [31:0] rv;
    res = '0;
    case (kind)
      REQ_STEP: advance_chain(amt);
      REQ_IMPULSE: begin
        mag = amt < 0 ? -amt : amt;
        for (int d = -3; d <= 3; d++) begin
          idx = pos + d;
          w = 4 - (d < 0 ? -d : d);
          if (idx >= 0 && idx < WAVE_POINTS) begin
            vel[idx] = clampl(vel[idx] + fshr(amt * w + 2, 2), -8388608, 8388607);
            nrg[idx] = clampl(nrg[idx] + fshr(mag * w + 2, 2), 0, 65536);
          end
        end
      end
      REQ_EXCITE: begin
        w = qmul(amt, 1966);
        for (int i = 0; i < WAVE_POINTS; i++) nrg[i] = clampl(nrg[i] + w, 0, 65536);
      end
      REQ_TURB: if (amt > 0) begin
        for (int k = 0; k < 8; k++) begin
          idx = rand_next() % WAVE_POINTS;
          rv = rand_next();
          unit = fshr(longint'($signed(rv)), 17);
          vel[idx] = clampl(vel[idx] + qmul(qmul(unit, amt), 5734), -8388608, 8388607);
        end
      end
      REQ_CLEAR: wipe_chain();
      REQ_READ: if (pos < WAVE_POINTS) begin
        res.h = 24'(hgt[pos]);
        res.v = 24'(vel[pos]);
        res.e = 17'(nrg[pos]);
      end
      default: ;
    endcase
    read_q.push_back(res);
  endtask

  always @(posedge clk) begin
    read_t want;
    if (rst) begin
      seed_reg = SEED_RESET;
      wipe_chain();
      read_q.delete();
      errors <= 0;
      reads_seen <= 0;
    end else begin
      if (cfg_valid && cfg_ready) seed_reg = noise_seed;
      if (out_valid && !out_stall) begin
        if (read_q.size() == 0) begin
          $display("%0t: result with nothing expected: %h %h %h", $time, point_height,
                   point_velocity, point_energy);
          errors <= errors + 1;
        end else begin
          want = read_q.pop_front();
          if (want.h !== point_height || want.v !== point_velocity
              || want.e !== point_energy) begin
            $display("%0t: mismatch expected h=%0d v=%0d e=%0d actual h=%0d v=%0d e=%0d",
                     $time, want.h, want.v, want.e, point_height, point_velocity,
                     point_energy);
            errors <= errors + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        apply_request(req_type, position, longint'(amount));
        if (req_type == REQ_READ) reads_seen <= reads_seen + 1;
      end
    end
    pending <= read_q.size();
  end

endmodule

>>> tb/tb.sv
// Top of the damped wave chain testbench: clock, reset, request stimulus and verdict.
// Instantiates damped_wave_chain_sim_core and dwcs_checker; uses dwcs_pkg.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dwcs_pkg::*;

  localparam int WATCHDOG = 20000;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [2:0] req_type = REQ_STEP;
  logic [5:0] position = 0;
  logic signed [23:0] amount = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [23:0] point_height, point_velocity;
  logic [16:0] point_energy;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [31:0] noise_seed = 0;
  int errors, pending, reads_seen;
  int idle_cycles = 0;
  int items = 0;
  bit calm = 0;

  always #5 clk = ~clk;

  damped_wave_chain_sim_core dut (.*);
  dwcs_checker chk (.*);

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // random stall bursts on the result side
  initial begin
    int n;
    @(negedge rst);
    while (!calm) begin
      n = $urandom_range(1, 17);
      @(posedge clk) out_stall <= ($urandom_range(0, 2) == 0);
      repeat (n - 1) @(posedge clk);
    end
    @(posedge clk) out_stall <= 0;
  end

  task automatic send(logic [2:0] k, logic [5:0] p, logic signed [23:0] a);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    req_type <= k;
    position <= p;
    amount <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items++;
  endtask

  task automatic write_seed(logic [31:0] s);
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    cfg_valid <= 1;
    noise_seed <= s;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  task automatic read_all();
    for (int i = 0; i < 64; i += 5) send(REQ_READ, 6'(i), 24'($urandom));
  endtask

  function automatic logic signed [23:0] rand_amt();
    case ($urandom_range(0, 3))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return 24'($signed($urandom_range(0, 65535)) - 32768);
      default: return 24'($urandom);
    endcase
  endfunction

  initial begin
    logic [31:0] seeds [4];
    logic [2:0] k;
    seeds = '{32'd1, 32'hFFFFFFFF, 32'd0, 32'($urandom)};
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send(REQ_READ, 6'd0, 24'sd0);
    send(REQ_IMPULSE, 6'd0, 24'sh7FFFFF);
    send(REQ_IMPULSE, 6'd63, 24'sh800000);
    send(REQ_IMPULSE, 6'd31, 24'sd16384);
    send(REQ_EXCITE, 6'd0, 24'sh7FFFFF);
    send(REQ_EXCITE, 6'd0, -24'sd40000);
    send(REQ_STEP, 6'd0, 24'sd0);
    send(REQ_STEP, 6'd0, 24'sh7FFFFF);
    send(REQ_STEP, 6'd0, 24'sh800000);
    send(REQ_TURB, 6'd0, 24'sd0);
    send(REQ_TURB, 6'd0, -24'sd5);
    send(REQ_TURB, 6'd0, 24'sh7FFFFF);
    send(3'd6, 6'd7, 24'sd100);
    send(3'd7, 6'd63, -24'sd100);
    read_all();
    send(REQ_CLEAR, 6'd0, 24'sd0);
    send(REQ_READ, 6'd63, 24'sd0);
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) write_seed(seeds[ph - 1]);
      if (ph == 4) calm = 1;
      send(REQ_CLEAR, 6'($urandom), 24'($urandom));
      for (int n = 0; n < 360; n++) begin
        k = $urandom_range(0, 99) < 30 ? REQ_READ : 3'($urandom_range(0, 7));
        if (k == REQ_TURB && $urandom_range(0, 1)) k = REQ_STEP;
        send(k, 6'($urandom), rand_amt());
      end
      read_all();
    end
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    $display("tb: %0d requests sent, %0d reads checked, five seed settings incl. 0 and max",
             items, reads_seen);
    if (errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end
endmodule

>>> files.f
hdl/dwcs_pkg.sv
hdl/dwcs_cell.sv
hdl/dwcs_rng.sv
hdl/damped_wave_chain_sim_core.sv
tb/dwcs_checker.sv
tb/tb.sv
